// ===== design/brt_pkg.sv =====
// Shared types and constants for the balanced run trimmer.
// No dependencies; every other design file but brt_out_if uses this package.
package brt_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int TBL_AW        = $clog2(TABLE_SIZE);
  localparam int BRACKET_KINDS = 8;
  localparam int COUNT_BITS    = 16;
  localparam int CODE_W        = 9;
  localparam int KIND_W        = 4;
  localparam int POS_W         = 16;
  localparam int OPEN_W        = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TOKEN = 1'b1
  } op_e;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CODE_W-1:0]     code_t;

  typedef struct packed {
    logic              non_initial;
    logic              non_final;
    logic [KIND_W-1:0] closer;
    logic [KIND_W-1:0] opener;
  } class_t;

  typedef struct packed {
    logic   fire;
    logic   last;
    class_t cls;
  } scan_req_t;

  typedef struct packed {
    logic may_start;
    logic run_done;
    pos_t accepted_size;
  } result_t;

endpackage

// ===== design/brt_in_if.sv =====
// Input channel of the balanced run trimmer: table loads and run tokens.
// Depends on brt_pkg for the opcode type.
interface brt_in_if;
  logic                valid;
  logic                ready;
  brt_pkg::op_e        op;
  logic [8:0]          token_code;
  logic [3:0]          entry_opener_kind;
  logic [3:0]          entry_closer_kind;
  logic                entry_non_final;
  logic                entry_non_initial;
  logic                last;

  modport source (
    output valid, op, token_code, entry_opener_kind, entry_closer_kind,
           entry_non_final, entry_non_initial, last,
    input  ready
  );
  modport sink (
    input  valid, op, token_code, entry_opener_kind, entry_closer_kind,
           entry_non_final, entry_non_initial, last,
    output ready
  );
endinterface

// ===== design/brt_out_if.sv =====
// Result channel of the balanced run trimmer: one word per run token.
// No dependencies.
interface brt_out_if;
  logic        valid;
  logic        ready;
  logic        may_start;
  logic        run_done;
  logic [15:0] accepted_size;

  modport source (
    output valid, may_start, run_done, accepted_size,
    input  ready
  );
  modport sink (
    input  valid, may_start, run_done, accepted_size,
    output ready
  );
endinterface

// ===== design/brt_class_table.sv =====
// Token class table: a memory with registered read and per-entry valid bits.
// Depends on brt_pkg; entries never loaded since reset read as all zero.
module brt_class_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic            rd_en_i,
  input  brt_pkg::code_t  addr_i,
  input  brt_pkg::class_t wdata_i,
  output brt_pkg::class_t rdata_o
);
  import brt_pkg::*;

  class_t              mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_q;
  class_t              rdata_q;
  logic                hit_q;
  logic                in_range;
  logic [TBL_AW-1:0]   idx;

  assign in_range = {1'b0, addr_i} < (CODE_W + 1)'(TABLE_SIZE);
  assign idx      = addr_i[TBL_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      mem[idx] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i && in_range) begin
        valid_q[idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= in_range && valid_q[idx];
      end
    end
  end

  assign rdata_o = hit_q ? rdata_q : '0;
endmodule

// ===== design/brt_balance_scan.sv =====
// Per-run state: bracket balance counters, positions and the result length.
// Depends on brt_pkg; the result is combinational from the current token.
module brt_balance_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              function_mode_i,
  input  brt_pkg::scan_req_t req_i,
  output brt_pkg::result_t  res_o
);
  import brt_pkg::*;

  cnt_t              bal_q [BRACKET_KINDS];
  cnt_t              bal_d [BRACKET_KINDS];
  logic [OPEN_W-1:0] open_q, open_d;
  pos_t              pos_q, pos_d;
  pos_t              lfp_q, lfp_d;
  pos_t              best_q, best_d;
  logic              stop_q, stop_d;
  logic              opk_ok, clk_ok;

  assign opk_ok = (req_i.cls.opener != '0) &&
                  (req_i.cls.opener <= KIND_W'(BRACKET_KINDS));
  assign clk_ok = (req_i.cls.closer != '0) &&
                  (req_i.cls.closer <= KIND_W'(BRACKET_KINDS));

  always_comb begin
    bal_d  = bal_q;
    open_d = open_q;
    stop_d = stop_q;
    pos_d  = (pos_q != '1) ? pos_q + POS_W'(1) : pos_q;
    lfp_d  = req_i.cls.non_final ? lfp_q : pos_d;
    if (!stop_q) begin
      for (int i = 0; i < BRACKET_KINDS; i++) begin
        if (opk_ok && req_i.cls.opener == KIND_W'(i + 1)) begin
          if (bal_q[i] == '0) begin
            open_d = open_d + OPEN_W'(1);
          end
          if (bal_q[i] != '1) begin
            bal_d[i] = bal_q[i] + COUNT_BITS'(1);
          end
        end
      end
      for (int i = 0; i < BRACKET_KINDS; i++) begin
        if (clk_ok && req_i.cls.closer == KIND_W'(i + 1)) begin
          if (bal_d[i] == '0) begin
            stop_d = 1'b1;
          end else begin
            bal_d[i] = bal_d[i] - COUNT_BITS'(1);
            if (bal_d[i] == '0) begin
              open_d = open_d - OPEN_W'(1);
            end
          end
        end
      end
    end
    best_d = (!stop_q && !stop_d && open_d == '0) ? lfp_d : best_q;
  end

  always_comb begin
    res_o.may_start     = !req_i.cls.non_initial;
    res_o.run_done      = req_i.last;
    res_o.accepted_size = '0;
    if (req_i.last) begin
      res_o.accepted_size = function_mode_i ? best_d : lfp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BRACKET_KINDS; i++) begin
        bal_q[i] <= '0;
      end
      open_q <= '0;
      pos_q  <= '0;
      lfp_q  <= '0;
      best_q <= '0;
      stop_q <= 1'b0;
    end else if (req_i.fire) begin
      if (req_i.last) begin
        for (int i = 0; i < BRACKET_KINDS; i++) begin
          bal_q[i] <= '0;
        end
        open_q <= '0;
        pos_q  <= '0;
        lfp_q  <= '0;
        best_q <= '0;
        stop_q <= 1'b0;
      end else begin
        bal_q  <= bal_d;
        open_q <= open_d;
        pos_q  <= pos_d;
        lfp_q  <= lfp_d;
        best_q <= best_d;
        stop_q <= stop_d;
      end
    end
  end
endmodule

// ===== design/balanced_run_trimmer_top.sv =====
// Top level of the balanced run trimmer.
// Depends on brt_pkg, brt_in_if, brt_out_if, brt_class_table and brt_balance_scan.
//
// The input channel carries two kinds of words. A load word writes one entry
// of the token class table; codes beyond the table are dropped. A token word
// belongs to the current run and is marked last on its final token. Each
// token word gives exactly one result word; load words give none.
// A word accepted at a clock edge reads the class table at that edge; its result
// enters the result register once the output can advance. One word is accepted
// every cycle while the output is not stalled; the table read port and the single
// counter update per token set that figure. The result register decouples the
// channels: while it is empty or being taken, a new input word is accepted. When
// the receiver stalls, the input is held off and the pending token waits with its
// table data. The function mode register is written through cfg_we_i, and the
// user must write it only while the block is idle; the block itself does not
// enforce this. Reset clears the class table, mode and all run state at once.
module balanced_run_trimmer_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  brt_in_if.sink   in_i,
  brt_out_if.source out_o
);
  import brt_pkg::*;

  logic      mode_q;
  logic      advance;
  logic      accept;
  logic      s1_valid_q;
  op_e       s1_op_q;
  logic      s1_last_q;
  logic      out_valid_q;
  result_t   out_q;
  class_t    wdata;
  class_t    rdata;
  scan_req_t req;
  result_t   res;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;

  assign wdata.opener      = in_i.entry_opener_kind;
  assign wdata.closer      = in_i.entry_closer_kind;
  assign wdata.non_final   = in_i.entry_non_final;
  assign wdata.non_initial = in_i.entry_non_initial;

  brt_class_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept && in_i.op == OP_LOAD),
    .rd_en_i (accept),
    .addr_i  (in_i.token_code),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign req.fire = advance && s1_valid_q && s1_op_q == OP_TOKEN;
  assign req.last = s1_last_q;
  assign req.cls  = rdata;

  brt_balance_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .function_mode_i (mode_q),
    .req_i           (req),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (advance) begin
        s1_valid_q  <= in_i.valid;
        out_valid_q <= req.fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= in_i.op;
      s1_last_q <= in_i.last;
    end
    if (req.fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.may_start     = out_q.may_start;
  assign out_o.run_done      = out_q.run_done;
  assign out_o.accepted_size = out_q.accepted_size;
endmodule

// ===== tb/brt_run_length_checker.sv =====
// Checker for the balanced run trimmer: watches the mode port and both channels,
// predicts the result word of every token word and compares it field by field.
// Depends on brt_pkg, brt_in_if and brt_out_if.
`timescale 1ns / 100ps
module brt_run_length_checker
  import brt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  brt_in_if    in_i,
  brt_out_if   res_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  class_t            class_mem [TABLE_SIZE];
  cnt_t              balance   [BRACKET_KINDS];
  logic [OPEN_W-1:0] open_kinds;
  pos_t              position;
  pos_t              trimmed_len;
  pos_t              balanced_len;
  logic              overrun;
  logic              mode_q;
  result_t           size_q [$];
  result_t           want;
  logic              bad;
  int                mismatches = 0;
  int                checked = 0;

  function automatic void clear_run();
    foreach (balance[k]) balance[k] = '0;
    open_kinds   = '0;
    position     = '0;
    trimmed_len  = '0;
    balanced_len = '0;
    overrun      = 1'b0;
  endfunction

  function automatic result_t predict_token(code_t code, logic is_last);
    class_t            cls;
    logic [KIND_W-1:0] opk;
    logic [KIND_W-1:0] clk_k;
    result_t           res;
    cls   = (code < TABLE_SIZE) ? class_mem[code[TBL_AW-1:0]] : '0;
    opk   = (cls.opener > BRACKET_KINDS) ? '0 : cls.opener;
    clk_k = (cls.closer > BRACKET_KINDS) ? '0 : cls.closer;
    if (position != '1) position = position + POS_W'(1);
    if (!cls.non_final) trimmed_len = position;
    // Once a closer finds its kind not open, the balance scan is frozen for the run.
    if (!overrun) begin
      if (opk != '0) begin
        if (balance[opk - 1] == '0) open_kinds = open_kinds + OPEN_W'(1);
        if (balance[opk - 1] != '1) balance[opk - 1] = balance[opk - 1] + COUNT_BITS'(1);
      end
      if (clk_k != '0) begin
        if (balance[clk_k - 1] == '0) begin
          overrun = 1'b1;
        end else begin
          balance[clk_k - 1] = balance[clk_k - 1] - COUNT_BITS'(1);
          if (balance[clk_k - 1] == '0) open_kinds = open_kinds - OPEN_W'(1);
        end
      end
      if (!overrun && open_kinds == '0) balanced_len = trimmed_len;
    end
    res.may_start     = !cls.non_initial;
    res.run_done      = is_last;
    res.accepted_size = is_last ? (mode_q ? balanced_len : trimmed_len) : '0;
    if (is_last) clear_run();
    return res;
  endfunction

  function automatic bit field_ok(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v === exp_v) return 1'b1;
    $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (class_mem[i]) class_mem[i] = '0;
      clear_run();
      mode_q = 1'b0;
      size_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (size_q.size() == 0) begin
          $display("%0t: result word expected none, got may_start=%0b run_done=%0b size=%0d",
                   $time, res_i.may_start, res_i.run_done, res_i.accepted_size);
          mismatches++;
        end else begin
          want = size_q.pop_front();
          bad  = !field_ok("may_start", 16'(want.may_start), 16'(res_i.may_start))
               | !field_ok("run_done", 16'(want.run_done), 16'(res_i.run_done))
               | !field_ok("accepted_size", want.accepted_size, res_i.accepted_size);
          if (bad) mismatches++;
          checked++;
        end
      end
      if (cfg_we_i) mode_q = cfg_wdata_i;
      if (in_i.valid && in_i.ready) begin
        if (in_i.op == OP_LOAD) begin
          if (in_i.token_code < TABLE_SIZE) begin
            class_mem[in_i.token_code[TBL_AW-1:0]] = '{in_i.entry_non_initial,
                                                       in_i.entry_non_final,
                                                       in_i.entry_closer_kind,
                                                       in_i.entry_opener_kind};
          end
        end else begin
          size_q.push_back(predict_token(in_i.token_code, in_i.last));
        end
      end
      pending_o    <= size_q.size();
      mismatches_o <= mismatches;
      checked_o    <= checked;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the balanced run trimmer: clock, reset, class table loads,
// token runs under varying idle and stall rates, and the final verdict.
// Depends on brt_pkg, both channel interfaces, the block and brt_run_length_checker.
`timescale 1ns / 100ps
module tb_top;
  import brt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 360;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatches;
  int   pending;
  int   checked;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  int   words_sent = 0;
  int   loads_sent = 0;
  int   runs_sent = 0;
  int   mode_writes = 0;
  logic cur_mode = 1'b0;

  brt_in_if  in_c ();
  brt_out_if out_c ();

  balanced_run_trimmer_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_c),
    .out_o      (out_c)
  );

  brt_run_length_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_c),
    .res_i       (out_c),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_c.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_c.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("balanced_run_trimmer_top test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input op_e op, input code_t code, input logic [3:0] opk,
                           input logic [3:0] clk_k, input logic nf, input logic ni,
                           input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_c.valid <= 1'b0;
      @(posedge clk);
    end
    in_c.valid             <= 1'b1;
    in_c.op                <= op;
    in_c.token_code        <= code;
    in_c.entry_opener_kind <= opk;
    in_c.entry_closer_kind <= clk_k;
    in_c.entry_non_final   <= nf;
    in_c.entry_non_initial <= ni;
    in_c.last              <= is_last;
    do @(posedge clk); while (!in_c.ready);
    words_sent++;
    if (op == OP_LOAD) loads_sent++;
  endtask

  task automatic send_token(input code_t code, input logic is_last);
    send_word(OP_TOKEN, code, 4'($urandom_range(15)), 4'($urandom_range(15)),
              1'($urandom_range(1)), 1'($urandom_range(1)), is_last);
    if (is_last) runs_sent++;
  endtask

  task automatic send_load(input code_t code, input logic [3:0] opk, input logic [3:0] clk_k,
                           input logic nf, input logic ni);
    send_word(OP_LOAD, code, opk, clk_k, nf, ni, 1'($urandom_range(1)));
  endtask

  task automatic random_load();
    int    r;
    code_t code;
    r = $urandom_range(99);
    if (r < 70) code = code_t'($urandom_range(32, 255));
    else if (r < 95) code = code_t'($urandom_range(256, 511));
    else code = code_t'($urandom_range(16, 31));
    send_load(code, 4'($urandom_range(15)), 4'($urandom_range(15)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic wait_for_results();
    in_c.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  // Codes 0-7 open kinds 1-8, codes 8-15 close them, codes 16-31 are plain words.
  task automatic load_layout();
    for (int k = 0; k < 8; k++) begin
      send_load(code_t'(k), 4'(k + 1), 4'd0, ($urandom_range(4) == 0), 1'($urandom_range(1)));
      send_load(code_t'(k + 8), 4'd0, 4'(k + 1), ($urandom_range(4) == 0),
                1'($urandom_range(1)));
    end
    for (int c = 16; c < 32; c++) send_load(code_t'(c), 4'd0, 4'd0, c[0], c[1]);
    repeat (20) random_load();
  endtask

  task automatic random_run(input bit flip);
    int    len;
    int    r;
    int    k;
    bit    tidy;
    code_t code;
    int    open_stack [$];
    len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    tidy = ($urandom_range(99) < 80);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) random_load();
      if (flip && i > 0 && i == len / 2) set_mode(!cur_mode);
      r = $urandom_range(99);
      if (!tidy) begin
        code = $urandom_range(1) ? code_t'($urandom_range(511)) : code_t'($urandom_range(31));
      end else if (open_stack.size() > 0 &&
                   (r < 35 || (len - i <= open_stack.size() && r < 80))) begin
        code = code_t'(8 + open_stack.pop_back());
      end else if (r < 65) begin
        k = $urandom_range(7);
        open_stack.push_back(k);
        code = code_t'(k);
      end else if (r < 92) begin
        code = code_t'($urandom_range(16, 31));
      end else begin
        code = code_t'($urandom_range(32, 511));
      end
      send_token(code, i == len - 1);
    end
  endtask

  initial begin
    int phase_start;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = 1'b0;
    in_c.valid             = 1'b0;
    in_c.op                = OP_LOAD;
    in_c.token_code        = '0;
    in_c.entry_opener_kind = '0;
    in_c.entry_closer_kind = '0;
    in_c.entry_non_final   = 1'b0;
    in_c.entry_non_initial = 1'b0;
    in_c.last              = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_load(code_t'(0), 4'd1, 4'd0, 1'b0, 1'b0);
    send_load(code_t'(1), 4'd0, 4'd1, 1'b0, 1'b0);
    send_load(code_t'(2), 4'd0, 4'd0, 1'b1, 1'b0);
    send_load(code_t'(3), 4'd0, 4'd0, 1'b0, 1'b1);
    send_load(code_t'(255), 4'd8, 4'd8, 1'b1, 1'b1);
    send_load(code_t'(300), 4'd1, 4'd1, 1'b1, 1'b1);
    send_load(code_t'(5), 4'd9, 4'd15, 1'b0, 1'b0);
    send_token(code_t'(0), 1'b0);
    send_token(code_t'(2), 1'b0);
    send_token(code_t'(44), 1'b1);
    set_mode(1'b1);
    send_token(code_t'(0), 1'b0);
    send_token(code_t'(0), 1'b0);
    send_token(code_t'(1), 1'b0);
    send_token(code_t'(2), 1'b0);
    send_token(code_t'(1), 1'b0);
    send_token(code_t'(3), 1'b0);
    send_token(code_t'(2), 1'b1);
    send_token(code_t'(1), 1'b0);
    send_token(code_t'(0), 1'b1);
    send_token(code_t'(255), 1'b0);
    send_token(code_t'(5), 1'b0);
    send_token(code_t'(400), 1'b0);
    send_token(code_t'(3), 1'b1);
    send_token(code_t'(0), 1'b1);
    send_token(code_t'(0), 1'b0);
    send_token(code_t'(1), 1'b0);
    set_mode(1'b0);
    send_token(code_t'(2), 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 70 : (p == 3) ? 34 : 0;
      stall_pct = (p == 2) ? 70 : (p == 3) ? 34 : 0;
      set_mode(p[0]);
      load_layout();
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        random_run($urandom_range(19) == 0);
        if ($urandom_range(14) == 0) wait_for_results();
      end
    end
    wait_for_results();

    $display("Sent %0d words: %0d table loads and %0d runs of mixed bracket shapes.",
             words_sent, loads_sent, runs_sent);
    $display("Checked %0d result words over %0d mode writes and four idle and stall mixes.",
             checked, mode_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("balanced_run_trimmer_top test passed");
    end else begin
      $display("balanced_run_trimmer_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/brt_pkg.sv
design/brt_in_if.sv
design/brt_out_if.sv
design/brt_class_table.sv
design/brt_balance_scan.sv
design/balanced_run_trimmer_top.sv
tb/brt_run_length_checker.sv
tb/tb_top.sv
